// ===== src/sdrb_pkg.sv =====
`timescale 1ns / 1ps
package sdrb_pkg;

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_SYNC   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_ACTIVE = 3'd4;

    localparam int FRAME_W = 48;
    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] left_sample;
        logic signed [31:0] right_sample;
        logic               left_not_finite;
        logic               right_not_finite;
        logic [15:0]        delay_frames;
        logic               active_value;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic               frame_valid;
        logic               write_accepted;
        logic [10:0]        fill_frames;
        logic               is_active;
    } t_out_item;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [15:0]        delay_frames;
        logic               active_value;
    } t_q_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== src/sdrb_ram.sv =====
`timescale 1ns / 1ps
module sdrb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sdrb_queue.sv =====
`timescale 1ns / 1ps
module sdrb_queue
    import sdrb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_item,
    input  logic    i_pop,
    output t_q_item o_item,
    output t_q_stat o_stat
);

    t_q_item          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !(i_push && !i_pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

// ===== src/sdrb_front.sv =====
`timescale 1ns / 1ps
module sdrb_front
    import sdrb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  t_q_stat  i_q_stat,
    output logic     o_busy,
    output logic     o_push,
    output t_q_item  o_q_item
);

    localparam logic signed [31:0] SAMPLE_MAX = 32'sd4194304;
    localparam logic signed [31:0] SAMPLE_MIN = -32'sd4194304;

    function automatic logic signed [23:0] clamp_sample(
        input logic signed [31:0] v,
        input logic               nf
    );
        logic signed [23:0] res;
        if (nf) begin
            res = '0;
        end else if (v > SAMPLE_MAX) begin
            res = SAMPLE_MAX[23:0];
        end else if (v < SAMPLE_MIN) begin
            res = SAMPLE_MIN[23:0];
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    logic    r_fv;
    t_q_item r_q;
    t_q_item n_q;
    logic    accept;

    assign o_busy = r_fv && i_q_stat.full;
    assign o_push = r_fv && !i_q_stat.full;
    assign accept = i_start && !o_busy;

    always_comb begin
        n_q.command      = i_item.command;
        n_q.left         = clamp_sample(i_item.left_sample, i_item.left_not_finite);
        n_q.right        = clamp_sample(i_item.right_sample, i_item.right_not_finite);
        n_q.delay_frames = i_item.delay_frames;
        n_q.active_value = i_item.active_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q <= n_q;
        end
    end

    assign o_q_item = r_q;

endmodule

// ===== src/sdrb_back.sv =====
`timescale 1ns / 1ps
module sdrb_back
    import sdrb_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_item   i_q_item,
    input  t_q_stat   i_q_stat,
    output logic      o_q_pop,
    output t_out_item o_result,
    output logic      o_strobe
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW = AW + 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int XW = (FW > 16) ? FW : 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    t_state      r_state, n_state;
    t_q_item     r_item, n_item;
    logic [AW-1:0] r_wslot, n_wslot;
    logic [AW-1:0] r_rslot, n_rslot;
    logic [FW-1:0] r_fill, n_fill;
    logic        r_active, n_active;
    logic        r_resync, n_resync;
    logic [15:0] r_silence, n_silence;
    logic [15:0] r_delay, n_delay;
    t_out_item   r_res, n_res;
    logic        r_strobe, n_strobe;

    logic                ram_we;
    logic                ram_re;
    logic [FRAME_W-1:0]  ram_rdata;

    logic [15:0]   req;
    logic [16:0]   grow;
    logic [15:0]   red;
    logic [15:0]   from_sil;
    logic [15:0]   rem;
    logic [XW-1:0] rem_x;
    logic [XW-1:0] fill_x;
    logic [XW-1:0] skip_x;
    logic [FW-1:0] skip;
    logic [SW-1:0] skip_sum;
    logic [AW-1:0] skip_slot;
    logic [AW-1:0] wslot_inc;
    logic [AW-1:0] rslot_inc;

    assign req       = r_item.delay_frames;
    assign grow      = {1'b0, r_silence} + {1'b0, req - r_delay};
    assign red       = r_delay - req;
    assign from_sil  = (red < r_silence) ? red : r_silence;
    assign rem       = red - from_sil;
    assign rem_x     = XW'(rem);
    assign fill_x    = XW'(r_fill);
    assign skip_x    = (rem_x < fill_x) ? rem_x : fill_x;
    assign skip      = FW'(skip_x);
    assign skip_sum  = SW'(r_rslot) + SW'(skip);
    assign skip_slot = (skip_sum >= SW'(CAPACITY)) ? AW'(skip_sum - SW'(CAPACITY))
                                                   : AW'(skip_sum);
    assign wslot_inc = (r_wslot == AW'(CAPACITY - 1)) ? '0 : r_wslot + 1'b1;
    assign rslot_inc = (r_rslot == AW'(CAPACITY - 1)) ? '0 : r_rslot + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_wslot   = r_wslot;
        n_rslot   = r_rslot;
        n_fill    = r_fill;
        n_active  = r_active;
        n_resync  = r_resync;
        n_silence = r_silence;
        n_delay   = r_delay;
        n_res     = r_res;
        n_strobe  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        o_q_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_res   = '0;
                unique case (r_item.command)
                    CMD_WRITE: begin
                        if (r_fill != FW'(CAPACITY)) begin
                            ram_we               = 1'b1;
                            n_wslot              = wslot_inc;
                            n_fill               = r_fill + 1'b1;
                            n_res.write_accepted = 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (r_active) begin
                            if (r_silence != '0) begin
                                n_silence         = r_silence - 1'b1;
                                n_res.frame_valid = 1'b1;
                            end else if (r_fill != '0) begin
                                ram_re  = 1'b1;
                                n_rslot = rslot_inc;
                                n_fill  = r_fill - 1'b1;
                                n_state = S_READ;
                            end
                        end
                    end
                    CMD_SYNC: begin
                        if (r_resync) begin
                            n_resync  = 1'b0;
                            n_delay   = req;
                            n_silence = req;
                        end else if (r_active && req != r_delay) begin
                            if (req > r_delay) begin
                                n_silence = grow[16] ? 16'hFFFF : grow[15:0];
                            end else begin
                                n_silence = r_silence - from_sil;
                                n_rslot   = skip_slot;
                                n_fill    = r_fill - skip;
                            end
                            n_delay = req;
                        end
                    end
                    CMD_CLEAR: begin
                        n_rslot = r_wslot;
                        n_fill  = '0;
                    end
                    CMD_ACTIVE: begin
                        if (r_item.active_value && !r_active) begin
                            n_resync = 1'b1;
                        end
                        n_active = r_item.active_value;
                    end
                    default: ;
                endcase
                n_res.fill_frames = 11'(n_fill);
                n_res.is_active   = n_active;
                n_strobe          = (n_state == S_IDLE);
            end
            S_READ: begin
                n_res.left_out       = ram_rdata[47:24];
                n_res.right_out      = ram_rdata[23:0];
                n_res.frame_valid    = 1'b1;
                n_res.write_accepted = 1'b0;
                n_res.fill_frames    = 11'(r_fill);
                n_res.is_active      = r_active;
                n_strobe             = 1'b1;
                n_state              = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wslot   <= '0;
            r_rslot   <= '0;
            r_fill    <= '0;
            r_active  <= 1'b0;
            r_resync  <= 1'b0;
            r_silence <= '0;
            r_delay   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wslot   <= n_wslot;
            r_rslot   <= n_rslot;
            r_fill    <= n_fill;
            r_active  <= n_active;
            r_resync  <= n_resync;
            r_silence <= n_silence;
            r_delay   <= n_delay;
            r_strobe  <= n_strobe;
        end
        r_item <= n_item;
        r_res  <= n_res;
    end

    sdrb_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata ({r_item.left, r_item.right}),
        .i_re    (ram_re),
        .i_raddr (r_rslot),
        .o_rdata (ram_rdata)
    );

    assign o_result = r_res;
    assign o_strobe = r_strobe;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for two cycles");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CAPACITY))
        else $error("fill exceeds capacity");
    a_pop_or_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !(r_res.frame_valid && r_res.write_accepted))
        else $error("result marks both pop and write");
    a_read_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(r_state) == S_EXEC && $past(r_item.command) == CMD_POP))
        else $error("store read without pop");

endmodule

// ===== src/stereo_delay_ring_buffer.sv =====
`timescale 1ns / 1ps
// Channel   Ports                         Transaction
// command   start, busy, i_item           start high and busy low at a rising edge
// result    o_strobe, o_result            o_strobe high for one cycle, always taken
//
// Each command yields one result via the input register, the queue, the unit's EXEC state
// and the result register, a store pop also via READ (registered RAM read). The unit pops a
// new command only when idle; a two-entry queue sits between input register and unit.
// Synchronous active-low reset empties the FIFO and clears active, resync, silence and delay
// state; the frame store itself is not cleared. busy rises only when the input register and
// the queue are both full; the result side never stalls.
module stereo_delay_ring_buffer
    import sdrb_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic    push;
    logic    pop;
    t_q_item front_item;
    t_q_item head_item;
    t_q_stat q_stat;

    sdrb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_busy   (busy),
        .o_push   (push),
        .o_q_item (front_item)
    );

    sdrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    sdrb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_item (head_item),
        .i_q_stat (q_stat),
        .o_q_pop  (pop),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule
